[sv/kth_order_difference_decoder_macros.svh]
// ---------------------------------------------------------------------------
// kth_order_difference_decoder_macros.svh
// Assertion helpers shared by the difference decoder modules.
// Both expect signals named clk and rst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef KTH_ORDER_DIFFERENCE_DECODER_MACROS_SVH
`define KTH_ORDER_DIFFERENCE_DECODER_MACROS_SVH

// Same-cycle implication
`define KDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define KDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/kdd_pkg.sv]
// ---------------------------------------------------------------------------
// kdd_pkg
// Types and constants for the k-th order difference decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package kdd_pkg;

    localparam int unsigned DATA_W  = 64;
    localparam int unsigned ORDER_W = 3;
    localparam int unsigned FILL_W  = 4;
    localparam int unsigned COEF_W  = 6;

    // Reset value of the order register
    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

    typedef logic [DATA_W-1:0]  data_t;
    typedef logic [ORDER_W-1:0] order_t;
    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [COEF_W-1:0]  coef_t;

    // Pascal triangle, row = order in use, column = steps back
    localparam coef_t BINOM_C [8][8] = '{
        '{6'd1, 6'd0, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd1, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd2, 6'd1,  6'd0,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd3, 6'd3,  6'd1,  6'd0,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd4, 6'd6,  6'd4,  6'd1,  6'd0,  6'd0, 6'd0},
        '{6'd1, 6'd5, 6'd10, 6'd10, 6'd5,  6'd1,  6'd0, 6'd0},
        '{6'd1, 6'd6, 6'd15, 6'd20, 6'd15, 6'd6,  6'd1, 6'd0},
        '{6'd1, 6'd7, 6'd21, 6'd35, 6'd35, 6'd21, 6'd7, 6'd1}
    };

    // Control from the stream stage to the reconstruction core
    typedef struct packed {
        logic   advance;   // item moves from input reg to result reg
        logic   restart;   // clear history before this item
        order_t order;     // clamped order k
    } kdd_ctl_t;

endpackage

`default_nettype wire

[sv/kdd_core.sv]
// ---------------------------------------------------------------------------
// kdd_core
// History store, fill count and single-pass value reconstruction.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kth_order_difference_decoder_macros.svh"

module kdd_core #(
    parameter int unsigned MAX_ORDER_P = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kdd_pkg::kdd_ctl_t ctl,
    input  wire kdd_pkg::data_t   delta,
    output kdd_pkg::data_t        value
);
    import kdd_pkg::*;

    data_t hist_reg  [MAX_ORDER_P];
    data_t hist_next [MAX_ORDER_P];
    data_t hist_eff  [MAX_ORDER_P];
    fill_t fill_count_reg;
    fill_t fill_count_next;
    fill_t fill_eff;
    order_t m_use;
    data_t  y;

    // Restart clears the history before it is used
    always_comb
    begin
        for (int j = 0; j < MAX_ORDER_P; j++)
        begin
            hist_eff[j] = ctl.restart ? '0 : hist_reg[j];
        end
        fill_eff = ctl.restart ? '0 : fill_count_reg;
    end

    // Order in use: smaller of fill count and k
    assign m_use = (fill_eff < {1'b0, ctl.order}) ? fill_eff[ORDER_W-1:0] : ctl.order;

    // Weighted sum with alternating signs; coefficients past m are zero
    always_comb
    begin
        data_t term;
        y = delta;
        for (int i = 1; i <= MAX_ORDER_P; i++)
        begin
            term = hist_eff[i-1] * {{(DATA_W-COEF_W){1'b0}}, BINOM_C[m_use][i]};
            if (i % 2 == 1)
            begin
                y = y + term;
            end
            else
            begin
                y = y - term;
            end
        end
    end

    assign value = y;

    // Shift only the newest k entries; the rest keep their contents
    always_comb
    begin
        hist_next[0] = (ctl.order != '0) ? y : hist_eff[0];
        for (int j = 1; j < MAX_ORDER_P; j++)
        begin
            if (ORDER_W'(j) < ctl.order)
            begin
                hist_next[j] = hist_eff[j-1];
            end
            else
            begin
                hist_next[j] = hist_eff[j];
            end
        end
        if (fill_eff < ({1'b0, ctl.order} + fill_t'(1)))
        begin
            fill_count_next = fill_eff + fill_t'(1);
        end
        else
        begin
            fill_count_next = fill_eff;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_ORDER_P; j++)
            begin
                hist_reg[j] <= '0;
            end
            fill_count_reg <= '0;
        end
        else if (ctl.advance)
        begin
            for (int j = 0; j < MAX_ORDER_P; j++)
            begin
                hist_reg[j] <= hist_next[j];
            end
            fill_count_reg <= fill_count_next;
        end
    end

    `KDD_ASSERT_NOW(a_fill_bound, 1'b1, fill_count_reg <= fill_t'(MAX_ORDER_P + 1),
        "fill count above its saturation limit")
    `KDD_ASSERT_NEXT(a_restart_fill, ctl.advance && ctl.restart, fill_count_reg == fill_t'(1),
        "fill count not one after a restart item")
    `KDD_ASSERT_NEXT(a_hold_state, !ctl.advance,
        $stable(fill_count_reg) && $stable(hist_reg[0]),
        "decoder state changed without an item")

endmodule

`default_nettype wire

[sv/kth_order_difference_decoder.sv]
// Path: input register, then reconstruction, then result register on m_tdata.
// Throughput: one item per cycle while m_tready does not stall; the history
//   feedback closes combinationally through the reconstruction adder tree.
// Reset (rst_n, async, active low): history and fill count cleared,
//   diff_order set to 3, both stream stages empty.
// ---------------------------------------------------------------------------
// kth_order_difference_decoder
// Rebuilds integer values from k-th order differences, one per item.
// ---------------------------------------------------------------------------
`default_nettype none
`include "kth_order_difference_decoder_macros.svh"

module kth_order_difference_decoder #(
    parameter int unsigned MAX_ORDER_P = 7
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 cfg_we,
    input  wire kdd_pkg::order_t      cfg_wdata,   // diff_order
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire kdd_pkg::data_t       s_tdata,     // [63:0] delta
    input  wire logic                 s_tuser,     // [0] restart
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output kdd_pkg::data_t            m_tdata      // [63:0] value
);
    import kdd_pkg::*;

    order_t   diff_order_reg;
    order_t   k_use;
    logic     in_valid_reg;
    logic     restart_reg;
    data_t    delta_reg;
    logic     out_valid_reg;
    data_t    value_reg;
    data_t    value_next;
    logic     out_load;
    logic     advance;
    kdd_ctl_t ctl;

    // Order register, clamped on use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_order_reg <= ORDER_RESET;
        end
        else if (cfg_we)
        begin
            diff_order_reg <= cfg_wdata;
        end
    end

    assign k_use = (diff_order_reg > ORDER_W'(MAX_ORDER_P)) ? ORDER_W'(MAX_ORDER_P)
                                                            : diff_order_reg;

    // Handshake between the two stages
    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            restart_reg <= s_tuser;
            delta_reg   <= s_tdata;
        end
    end

    // Reconstruction core
    assign ctl = '{advance: advance, restart: restart_reg, order: k_use};

    kdd_core #(
        .MAX_ORDER_P(MAX_ORDER_P)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .delta (delta_reg),
        .value (value_next)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= value_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = value_reg;

    `KDD_ASSERT_NEXT(a_in_held, in_valid_reg && !advance, in_valid_reg,
        "pending item dropped from the input register")
    `KDD_ASSERT_NEXT(a_order_zero, advance && (k_use == '0), m_tdata == $past(delta_reg),
        "order zero item not passed through unchanged")
    `KDD_ASSERT_NOW(a_stall_full, !s_tready, in_valid_reg && out_valid_reg,
        "input stalled while a stage is free")

endmodule

`default_nettype wire

[test/kdd_checker.sv]
// ----------------------------------------------------------------------------
// kdd_checker
// Watches the configuration port and both item streams of the difference
// decoder. It rebuilds every value on its own copy of the history and fill
// count, queues it, and compares it against each output item.
// ----------------------------------------------------------------------------
module kdd_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  kdd_pkg::order_t cfg_wdata,
    input  logic            s_tvalid,
    input  logic            s_tready,
    input  kdd_pkg::data_t  s_tdata,     // [63:0] delta
    input  logic            s_tuser,     // [0] restart
    input  logic            m_tvalid,
    input  logic            m_tready,
    input  kdd_pkg::data_t  m_tdata,     // [63:0] value
    output int              fail_count,
    output int              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import kdd_pkg::data_t;

    localparam int HIST_DEPTH     = 7;
    localparam int ORDER_CAP      = 7;
    localparam int ORDER_AT_RESET = 3;

    // Model state: newest value at index 0
    data_t hist [HIST_DEPTH];
    int    fill;
    int    order;

    // Values predicted but not yet seen on the output
    data_t pending_values [$];

    // Value = delta + alternating binomial sum over the last m values
    function automatic data_t rebuild_value(input data_t delta);
        data_t acc;
        data_t coef;
        int    m;
        m    = (fill < order) ? fill : order;
        acc  = delta;
        coef = 64'd1;
        for (int i = 1; i <= m; i++)
        begin
            coef = coef * data_t'(m - i + 1) / data_t'(i);
            if (i % 2 == 1)
                acc = acc + coef * hist[i-1];
            else
                acc = acc - coef * hist[i-1];
        end
        return acc;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        data_t want;
        data_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist[i] = '0;
            fill        = 0;
            order       = ORDER_AT_RESET;
            fail_count  = 0;
            pending_values.delete();
            outstanding <= 0;
        end
        else
        begin
            // Input item: optional restart, rebuild, shift newest k entries
            if (s_tvalid && s_tready)
            begin
                if (s_tuser)
                begin
                    for (int i = 0; i < HIST_DEPTH; i++)
                        hist[i] = '0;
                    fill = 0;
                end
                want = rebuild_value(s_tdata);
                if (order > 0)
                begin
                    for (int i = order - 1; i > 0; i--)
                        hist[i] = hist[i-1];
                    hist[0] = want;
                end
                if (fill < order + 1)
                    fill = fill + 1;
                pending_values.push_back(want);
            end

            // Output item: compare with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (pending_values.size() == 0)
                begin
                    $error("value: no item expected, got %h", got);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = pending_values.pop_front();
                    if (got !== want)
                    begin
                        $error("value mismatch: expected %h, actual %h", want, got);
                        fail_count = fail_count + 1;
                    end
                end
            end

            // Order write leaves history and fill count alone
            if (cfg_we)
            begin
                order = int'(cfg_wdata);
                if (order > ORDER_CAP)
                    order = ORDER_CAP;
            end

            outstanding <= pending_values.size();
        end
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the k-th order difference decoder: a directed pass over order
// changes, stale history and wrapping, then random runs of differences at
// every order with random gaps on input and output. Checking is in kdd_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kdd_pkg::data_t;
    import kdd_pkg::order_t;

    localparam int    CYCLE_LIMIT = 400000;
    localparam int    DRAIN_WAIT  = 4;
    localparam data_t VAL_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam data_t VAL_MIN     = 64'h8000_0000_0000_0000;
    localparam data_t VAL_NEG1    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   cfg_we;
    order_t cfg_wdata;
    logic   s_tvalid;
    logic   s_tready;
    data_t  s_tdata;     // [63:0] delta
    logic   s_tuser;     // [0] restart
    logic   m_tvalid;
    logic   m_tready;
    data_t  m_tdata;     // [63:0] value

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit quiet       = 1'b0;

    kth_order_difference_decoder #(
        .MAX_ORDER_P (7)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    kdd_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Output back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left > 0 && !quiet)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end
        else
            m_tready <= 1'b1;
    end

    // Mix of small, mid-size, extreme and full-width differences
    function automatic data_t rand_delta();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return data_t'(longint'($urandom_range(0, 200)) - 64'sd100);
        else if (pick < 6)
            return {$urandom, $urandom};
        else if (pick == 6)
        begin
            case ($urandom_range(0, 3))
                0:       return VAL_MAX;
                1:       return VAL_MIN;
                2:       return VAL_NEG1;
                default: return '0;
            endcase
        end
        else
            return data_t'(longint'(int'($urandom)));
    endfunction

    // One item, with an optional idle burst in front
    task automatic send_item(input logic restart, input data_t delta);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= delta;
        s_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop sending and wait until every value has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_order(input order_t k);
        cfg_we    <= 1'b1;
        cfg_wdata <= k;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Runs that mostly open with a restart, with a rare stray restart inside
    task automatic random_phase(input int n_items);
        int   sent;
        int   run_len;
        logic restart;
        sent = 0;
        while (sent < n_items)
        begin
            run_len = $urandom_range(1, 40);
            for (int j = 0; j < run_len && sent < n_items; j++)
            begin
                if (j == 0)
                    restart = ($urandom_range(0, 3) != 0);
                else
                    restart = ($urandom_range(0, 49) == 0);
                send_item(restart, rand_delta());
                sent++;
            end
        end
    endtask

    initial
    begin
        int phase_order [9];
        phase_order = '{7, 0, 1, 4, 6, 2, 5, 3, 0};
        phase_order[8] = $urandom_range(0, 7);

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset order (3): fill phase, then wrapping at the extremes
        send_item(1'b1, 64'd100);
        send_item(1'b0, 64'd7);
        send_item(1'b0, data_t'(-64'sd3));
        send_item(1'b0, VAL_MAX);
        send_item(1'b0, VAL_MIN);
        send_item(1'b0, VAL_NEG1);
        send_item(1'b0, '0);
        drain();

        // Raise the order mid-stream; fill count keeps climbing to k+1
        write_order(order_t'(7));
        send_item(1'b0, 64'd1);
        send_item(1'b0, 64'd2);
        send_item(1'b0, VAL_NEG1);
        send_item(1'b0, VAL_MAX);
        send_item(1'b0, '0);
        drain();

        // Lower the order: fill count above k+1 stays, deep entries freeze
        write_order(order_t'(2));
        send_item(1'b0, 64'd3);
        send_item(1'b0, data_t'(-64'sd5));
        send_item(1'b0, '0);
        drain();

        // Raise again: frozen entries come back into use
        write_order(order_t'(5));
        send_item(1'b0, 64'd1);
        send_item(1'b0, 64'd1);
        drain();

        // Order zero: value passes straight through
        write_order(order_t'(0));
        send_item(1'b0, 64'd123);
        send_item(1'b1, data_t'(-64'sd9));
        send_item(1'b0, VAL_MIN);
        drain();

        // First order after restart
        write_order(order_t'(1));
        send_item(1'b1, 64'd10);
        send_item(1'b0, 64'd1);
        send_item(1'b0, 64'd1);
        drain();

        // Random runs at every order; the last phase runs without idling
        for (int p = 0; p < 9; p++)
        begin
            if (p == 8)
                quiet = 1'b1;
            write_order(order_t'(phase_order[p]));
            random_phase(200);
            drain();
        end

        if (fail_count == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/kdd_pkg.sv
sv/kdd_core.sv
sv/kth_order_difference_decoder.sv
test/kdd_checker.sv
test/tb_top.sv
